FILE: rtl/core/psdp_pkg.sv
// Shared types, widths and helpers for the 2x2 PSD projection pipeline.
`timescale 1ns / 1ps
`default_nettype none

package psdp_pkg;

  localparam int DATA_W     = 32;
  localparam int SQRT_GUARD = 16;

  // Square root: radicand (d^2 + 4b^2) before the guard shift, root width
  localparam int DG_W     = 49;
  localparam int RAD_W    = 2 * DG_W - 2 * SQRT_GUARD;
  localparam int SQ_STEPS = DG_W;
  localparam int SQ_REM_W = DG_W + 1;

  // Scaling multiply and divide
  localparam int OP_W      = 50;
  localparam int HALF_W    = OP_W / 2;
  localparam int PROD_W    = 2 * OP_W;
  localparam int QUO_W     = PROD_W - DG_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int LANES     = 3;
  localparam int RT_W      = QUO_W + 1 - (SQRT_GUARD + 2);

  // Lane codes
  localparam int LANE_DIAG0 = 0;
  localparam int LANE_DIAG1 = 1;
  localparam int LANE_OFF   = 2;

  // Register stage numbering
  localparam int FRONT_STAGES = 4;
  localparam int SQ_LAST      = FRONT_STAGES + SQ_STEPS;
  localparam int DIV_FIRST    = SQ_LAST + 3;
  localparam int DIV_LAST     = DIV_FIRST + DIV_STEPS;
  localparam int LATENCY      = DIV_LAST + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_left;
    logic signed [DATA_W-1:0] top_right;
    logic signed [DATA_W-1:0] bottom_left;
    logic signed [DATA_W-1:0] bottom_right;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] proj_top_left;
    logic signed [DATA_W-1:0] proj_top_right;
    logic signed [DATA_W-1:0] proj_bottom_left;
    logic signed [DATA_W-1:0] proj_bottom_right;
    logic                     overflow;
  } result_t;

  // Per-request data that travels beside the arithmetic
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] tr;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W:0]   s;
    logic signed [DATA_W:0]   d;
    logic        [DATA_W-1:0] ab;
    logic                     pass;
    logic                     zero;
  } side_t;

  typedef logic [LANES-1:0][PROD_W-1:0] prod_vec_t;
  typedef logic [LANES-1:0][QUO_W-1:0]  quo_vec_t;

  // Round a quotient half up, apply sign, saturate; returns {overflow, word}
  function automatic logic [DATA_W:0] round_lane(logic [QUO_W-1:0] t, logic neg);
    logic [QUO_W:0]         sum;
    logic signed [RT_W:0]   mag;
    logic signed [RT_W:0]   v;
    logic signed [RT_W:0]   hi_lim;
    logic signed [RT_W:0]   lo_lim;
    sum    = (QUO_W + 1)'(t) + (QUO_W + 1)'(2 ** (SQRT_GUARD + 1));
    mag    = {1'b0, sum[QUO_W:SQRT_GUARD+2]};
    v      = neg ? -mag : mag;
    hi_lim = (RT_W + 1)'(2 ** (DATA_W - 1) - 1);
    lo_lim = -hi_lim - (RT_W + 1)'(1);
    if (v > hi_lim) begin
      return {1'b1, DATA_W'(hi_lim)};
    end else if (v < lo_lim) begin
      return {1'b1, DATA_W'(lo_lim)};
    end
    return {1'b0, DATA_W'(v)};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/psdp_div.sv
// Pipelined restoring divider: three numerators over one shared divisor.
`timescale 1ns / 1ps
`default_nettype none

module psdp_div (
  input  wire                                clk,
  input  wire psdp_pkg::prod_vec_t           num,
  input  wire [psdp_pkg::DG_W-1:0]           den,
  output psdp_pkg::quo_vec_t                 quot
);

  logic [psdp_pkg::LANES-1:0][psdp_pkg::DG_W-1:0]  rem [1:psdp_pkg::DIV_STEPS];
  logic [psdp_pkg::LANES-1:0][psdp_pkg::QUO_W-1:0] lo  [1:psdp_pkg::DIV_STEPS-1];
  logic [psdp_pkg::LANES-1:0][psdp_pkg::QUO_W-1:0] quo [1:psdp_pkg::DIV_STEPS];
  logic [psdp_pkg::DG_W-1:0]                       dn  [1:psdp_pkg::DIV_STEPS-1];

  // One quotient bit per stage, MSB first
  for (genvar j = 1; j <= psdp_pkg::DIV_STEPS; j++) begin : g_step
    logic [psdp_pkg::LANES-1:0][psdp_pkg::DG_W-1:0]  rem_in;
    logic [psdp_pkg::LANES-1:0][psdp_pkg::QUO_W-1:0] lo_in;
    logic [psdp_pkg::LANES-1:0][psdp_pkg::QUO_W-1:0] quo_in;
    logic [psdp_pkg::DG_W-1:0]                       dn_in;

    if (j == 1) begin : g_first
      for (genvar l = 0; l < psdp_pkg::LANES; l++) begin : g_ld
        assign rem_in[l] = num[l][psdp_pkg::PROD_W-1:psdp_pkg::QUO_W];
        assign lo_in[l]  = num[l][psdp_pkg::QUO_W-1:0];
      end
      assign quo_in = '0;
      assign dn_in  = den;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign lo_in  = lo[j-1];
      assign quo_in = quo[j-1];
      assign dn_in  = dn[j-1];
    end

    for (genvar l = 0; l < psdp_pkg::LANES; l++) begin : g_lane
      logic [psdp_pkg::DG_W:0] trial;
      logic                    fits;
      assign trial = {rem_in[l], lo_in[l][psdp_pkg::QUO_W-j]};
      assign fits  = trial >= {1'b0, dn_in};
      always_ff @(posedge clk) begin
        rem[j][l] <= fits ? psdp_pkg::DG_W'(trial - {1'b0, dn_in})
                          : psdp_pkg::DG_W'(trial);
        quo[j][l] <= {quo_in[l][psdp_pkg::QUO_W-2:0], fits};
      end
    end

    // Carry the divisor and the unused numerator bits onward
    if (j < psdp_pkg::DIV_STEPS) begin : g_carry
      always_ff @(posedge clk) begin
        lo[j] <= lo_in;
        dn[j] <= dn_in;
      end
    end
  end

  assign quot = quo[psdp_pkg::DIV_STEPS];

endmodule

`default_nettype wire

FILE: rtl/core/psd_projection_2x2_unit.sv
// Top level: projection of a symmetric 2x2 matrix onto the PSD cone.
//
// A request (four signed 32-bit entries) is taken at each rising edge where
// start is high and busy is low. busy is held low: the pipeline takes one
// request every cycle, with no gaps needed between them.
// Each request gives exactly one result, shown on result for one cycle and
// marked by done; the receiver takes it at the edge that follows. Results
// leave in request order, one per cycle at most.
// The pipeline holds the 49-step square root of d^2 + 4b^2 and the 51-step
// divide by that root, one bit per register stage, plus four front-end
// stages, three stages of scaling multiply and the output rounding stage.
// The receiver cannot stall: results are not held, so it must take done.
// Reset (synchronous, active high) clears the valid bits only; requests in
// flight are dropped and no result appears for them.
`timescale 1ns / 1ps
`default_nettype none

module psd_projection_2x2_unit (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  wire psdp_pkg::request_t  request,
  output logic                     done,
  output psdp_pkg::result_t        result
);

  localparam int DW  = psdp_pkg::DATA_W;
  localparam int G   = psdp_pkg::SQRT_GUARD;
  localparam int OPW = psdp_pkg::OP_W;
  localparam int HW  = psdp_pkg::HALF_W;
  localparam int PW  = psdp_pkg::PROD_W;

  logic [psdp_pkg::LATENCY:1] vld;
  psdp_pkg::side_t            sd [1:psdp_pkg::DIV_LAST];
  psdp_pkg::side_t            sd3_next;

  logic signed [2*DW-1:0] ac1;
  logic signed [2*DW-1:0] bb1;
  logic signed [2*DW:0]   det2;
  logic [DW:0]            ad2;
  logic [2*DW-1:0]        bb2;
  logic [2*DW-1:0]        bb3;
  logic [DW+1:0]          pp_hh3;
  logic [DW:0]            pp_hl3;
  logic [DW-1:0]          pp_ll3;
  logic [psdp_pkg::RAD_W-1:0] q4;

  logic [psdp_pkg::SQ_REM_W-1:0] sq_rem  [1:psdp_pkg::SQ_STEPS];
  logic [psdp_pkg::DG_W-1:0]     sq_root [1:psdp_pkg::SQ_STEPS];
  logic [psdp_pkg::RAD_W-1:0]    sq_rad  [1:psdp_pkg::SQ_STEPS-1];

  logic [psdp_pkg::DG_W-1:0]   dg;
  logic signed [OPW:0]         n_sum;
  logic signed [OPW:0]         d_sh;
  logic signed [OPW:0]         e0_sum;
  logic signed [OPW:0]         e1_sum;

  logic [OPW-1:0]                          mul_x;
  logic [psdp_pkg::LANES-1:0][OPW-1:0]     mul_y;
  logic [psdp_pkg::DG_W-1:0]               dg_a;
  logic [psdp_pkg::LANES-1:0][OPW-1:0]     pp_ll;
  logic [psdp_pkg::LANES-1:0][OPW-1:0]     pp_lh;
  logic [psdp_pkg::LANES-1:0][OPW-1:0]     pp_hl;
  logic [psdp_pkg::LANES-1:0][OPW-1:0]     pp_hh;
  logic [psdp_pkg::DG_W-1:0]               dg_b;
  psdp_pkg::prod_vec_t                     prod_c;
  logic [psdp_pkg::DG_W-1:0]               dg_c;
  psdp_pkg::quo_vec_t                      quot;

  logic [psdp_pkg::LANES-1:0][DW:0]        lane_w;
  psdp_pkg::side_t                         fin;
  psdp_pkg::result_t                       result_next;

  assign busy = 1'b0;

  // Advance the valid bits; reset drops everything in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[psdp_pkg::LATENCY-1:1], start & ~busy};
    end
  end

  assign done = vld[psdp_pkg::LATENCY];

  // Stage 1: sum, difference, |b| and the two determinant products
  always_ff @(posedge clk) begin
    sd[1].a    <= request.top_left;
    sd[1].tr   <= request.top_right;
    sd[1].b    <= request.bottom_left;
    sd[1].c    <= request.bottom_right;
    sd[1].s    <= {request.top_left[DW-1], request.top_left}
                  + {request.bottom_right[DW-1], request.bottom_right};
    sd[1].d    <= {request.top_left[DW-1], request.top_left}
                  - {request.bottom_right[DW-1], request.bottom_right};
    sd[1].ab   <= request.bottom_left[DW-1] ? DW'(-request.bottom_left)
                                            : DW'(request.bottom_left);
    sd[1].pass <= 1'b0;
    sd[1].zero <= 1'b0;
    ac1        <= request.top_left * request.bottom_right;
    bb1        <= request.bottom_left * request.bottom_left;
  end

  // Stage 2: determinant and |d|
  always_ff @(posedge clk) begin
    sd[2] <= sd[1];
    det2  <= ac1 - bb1;
    ad2   <= sd[1].d[DW] ? (DW + 1)'(-sd[1].d) : (DW + 1)'(sd[1].d);
    bb2   <= bb1;
  end

  // Stage 3: branch flags and partial squares of |d|
  always_comb begin
    sd3_next      = sd[2];
    sd3_next.pass = !sd[2].s[DW] && !det2[2*DW];
    sd3_next.zero = sd[2].s[DW] && !det2[2*DW] && (det2 != '0);
  end

  always_ff @(posedge clk) begin
    sd[3]      <= sd3_next;
    pp_hh3     <= ad2[DW:G] * ad2[DW:G];
    pp_hl3     <= ad2[DW:G] * ad2[G-1:0];
    pp_ll3     <= ad2[G-1:0] * ad2[G-1:0];
    bb3        <= bb2;
  end

  // Stage 4: radicand d^2 + 4b^2
  always_ff @(posedge clk) begin
    sd[4] <= sd[3];
    q4    <= (psdp_pkg::RAD_W'(pp_hh3) << (2 * G))
             + (psdp_pkg::RAD_W'(pp_hl3) << (G + 1))
             + psdp_pkg::RAD_W'(pp_ll3)
             + (psdp_pkg::RAD_W'(bb3) << 2);
  end

  // Carry side data down the rest of the pipe
  for (genvar k = psdp_pkg::FRONT_STAGES + 1; k <= psdp_pkg::DIV_LAST; k++) begin : g_side
    always_ff @(posedge clk) begin
      sd[k] <= sd[k-1];
    end
  end

  // Square root of the radicand with guard bits, one root bit per stage
  for (genvar k = 1; k <= psdp_pkg::SQ_STEPS; k++) begin : g_sqrt
    localparam int I = psdp_pkg::SQ_STEPS - k;
    logic [psdp_pkg::SQ_REM_W-1:0] rem_in;
    logic [psdp_pkg::DG_W-1:0]     root_in;
    logic [psdp_pkg::RAD_W-1:0]    rad_in;
    logic [1:0]                    pair;
    logic [psdp_pkg::SQ_REM_W+1:0] shifted;
    logic [psdp_pkg::SQ_REM_W+1:0] trial;
    logic                          fits;

    if (k == 1) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = q4;
    end else begin : g_next
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
      assign rad_in  = sq_rad[k-1];
    end

    // Guard bits below the radicand are zero
    if (I >= G) begin : g_pair
      assign pair = rad_in[2*(I-G) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign shifted = {rem_in, pair};
    assign trial   = {1'b0, root_in, 2'b01};
    assign fits    = shifted >= trial;

    always_ff @(posedge clk) begin
      sq_rem[k]  <= fits ? psdp_pkg::SQ_REM_W'(shifted - trial)
                         : psdp_pkg::SQ_REM_W'(shifted);
      sq_root[k] <= {root_in[psdp_pkg::DG_W-2:0], fits};
    end

    if (k < psdp_pkg::SQ_STEPS) begin : g_rad
      always_ff @(posedge clk) begin
        sq_rad[k] <= rad_in;
      end
    end
  end

  assign dg = sq_root[psdp_pkg::SQ_STEPS];

  // Stage A: 2*hi (clamped at zero) and the three eigenvector terms
  always_comb begin
    n_sum  = {{(OPW + 1 - (DW + 1) - G){sd[psdp_pkg::SQ_LAST].s[DW]}},
              sd[psdp_pkg::SQ_LAST].s, {G{1'b0}}}
             + {2'b00, dg};
    d_sh   = {{(OPW + 1 - (DW + 1) - G){sd[psdp_pkg::SQ_LAST].d[DW]}},
              sd[psdp_pkg::SQ_LAST].d, {G{1'b0}}};
    e0_sum = {2'b00, dg} + d_sh;
    e1_sum = {2'b00, dg} - d_sh;
  end

  always_ff @(posedge clk) begin
    mul_x                       <= n_sum[OPW] ? '0 : n_sum[OPW-1:0];
    mul_y[psdp_pkg::LANE_DIAG0] <= e0_sum[OPW-1:0];
    mul_y[psdp_pkg::LANE_DIAG1] <= e1_sum[OPW-1:0];
    mul_y[psdp_pkg::LANE_OFF]   <= {{(OPW - DW - G - 1){1'b0}},
                                    sd[psdp_pkg::SQ_LAST].ab, {(G + 1){1'b0}}};
    dg_a                        <= dg;
  end

  // Stage B: split each product into four narrow partial products
  for (genvar l = 0; l < psdp_pkg::LANES; l++) begin : g_pp
    always_ff @(posedge clk) begin
      pp_ll[l] <= mul_x[HW-1:0]   * mul_y[l][HW-1:0];
      pp_lh[l] <= mul_x[HW-1:0]   * mul_y[l][OPW-1:HW];
      pp_hl[l] <= mul_x[OPW-1:HW] * mul_y[l][HW-1:0];
      pp_hh[l] <= mul_x[OPW-1:HW] * mul_y[l][OPW-1:HW];
    end
  end

  always_ff @(posedge clk) begin
    dg_b <= dg_a;
  end

  // Stage C: sum partial products
  for (genvar l = 0; l < psdp_pkg::LANES; l++) begin : g_sum
    always_ff @(posedge clk) begin
      prod_c[l] <= (PW'(pp_hh[l]) << OPW)
                   + ((PW'(pp_lh[l]) + PW'(pp_hl[l])) << HW)
                   + PW'(pp_ll[l]);
    end
  end

  always_ff @(posedge clk) begin
    dg_c <= dg_b;
  end

  psdp_div u_div (
    .clk  (clk),
    .num  (prod_c),
    .den  (dg_c),
    .quot (quot)
  );

  // Final stage: round, sign, saturate and choose the branch
  assign fin = sd[psdp_pkg::DIV_LAST];

  always_comb begin
    lane_w[psdp_pkg::LANE_DIAG0] = psdp_pkg::round_lane(quot[psdp_pkg::LANE_DIAG0], 1'b0);
    lane_w[psdp_pkg::LANE_DIAG1] = psdp_pkg::round_lane(quot[psdp_pkg::LANE_DIAG1], 1'b0);
    lane_w[psdp_pkg::LANE_OFF]   = psdp_pkg::round_lane(quot[psdp_pkg::LANE_OFF], fin.b[DW-1]);
    if (fin.pass) begin
      result_next.proj_top_left     = fin.a;
      result_next.proj_top_right    = fin.tr;
      result_next.proj_bottom_left  = fin.b;
      result_next.proj_bottom_right = fin.c;
      result_next.overflow          = 1'b0;
    end else if (fin.zero) begin
      result_next = '0;
    end else begin
      result_next.proj_top_left     = lane_w[psdp_pkg::LANE_DIAG0][DW-1:0];
      result_next.proj_top_right    = lane_w[psdp_pkg::LANE_OFF][DW-1:0];
      result_next.proj_bottom_left  = lane_w[psdp_pkg::LANE_OFF][DW-1:0];
      result_next.proj_bottom_right = lane_w[psdp_pkg::LANE_DIAG1][DW-1:0];
      result_next.overflow          = lane_w[psdp_pkg::LANE_DIAG0][DW]
                                      | lane_w[psdp_pkg::LANE_DIAG1][DW]
                                      | lane_w[psdp_pkg::LANE_OFF][DW];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Every result traces back to an accepted request
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start & ~busy, psdp_pkg::LATENCY))
    else $error("result without a matching request");

  // Pass-through and all-zero results never flag overflow
  a_no_ovf: assert property (@(posedge clk) disable iff (rst)
    (vld[psdp_pkg::DIV_LAST] && (fin.pass || fin.zero)) |=> !result.overflow)
    else $error("overflow raised outside the projection branch");

  // The projection branch always divides by a nonzero root
  a_root_nz: assert property (@(posedge clk) disable iff (rst)
    (vld[psdp_pkg::SQ_LAST] && !sd[psdp_pkg::SQ_LAST].pass
     && !sd[psdp_pkg::SQ_LAST].zero) |-> (dg != '0))
    else $error("zero divisor in projection branch");

endmodule

`default_nettype wire

FILE: dv/tb_psd_projection_2x2_unit.sv
// Testbench for the 2x2 PSD projection unit: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_psd_projection_2x2_unit;

  localparam int GUARD     = psdp_pkg::SQRT_GUARD;
  localparam int DRAIN_CYC = 200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  psdp_pkg::request_t request = '0;
  logic               done;
  psdp_pkg::result_t  result;

  int                 n_errors = 0;
  psdp_pkg::result_t  projections_due[$];

  psd_projection_2x2_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Generate clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Bound the run
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Round a scaled term half up and drop the guard bits
  function automatic logic signed [127:0] round_term(logic [127:0] t);
    return (t + (128'd1 << (GUARD + 1))) >> (GUARD + 2);
  endfunction

  // Saturate to 32 bits; returns {overflow, word}
  function automatic logic [32:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      return {1'b1, 32'h7fffffff};
    end
    if (v < -128'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, v[31:0]};
  endfunction

  // Work out the projected matrix for one request
  function automatic psdp_pkg::result_t project_psd(psdp_pkg::request_t rq);
    logic signed [127:0] a, b, c, s, d, det, n, e0, e1, p0, p1, p2;
    logic [127:0] ad, ab, rad, dg, root, cand, fb;
    logic [32:0] w0, w1, w2;
    psdp_pkg::result_t r;
    a = 128'(rq.top_left);
    b = 128'(rq.bottom_left);
    c = 128'(rq.bottom_right);
    s = a + c;
    d = a - c;
    det = a * c - b * b;
    r = '0;
    if (s >= 0 && det >= 0) begin
      r.proj_top_left     = rq.top_left;
      r.proj_top_right    = rq.top_right;
      r.proj_bottom_left  = rq.bottom_left;
      r.proj_bottom_right = rq.bottom_right;
      return r;
    end
    if (s < 0 && det > 0) return r;
    ad = (d < 0) ? -d : d;
    ab = (b < 0) ? -b : b;
    rad = (ad * ad + 4 * ab * ab) << (2 * GUARD);
    // Bitwise integer square root
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= rad) root = cand;
    end
    dg = root;
    n = (s <<< GUARD) + $signed(dg);
    if (n < 0) n = 0;
    e0 = $signed(dg) + (d <<< GUARD);
    e1 = $signed(dg) - (d <<< GUARD);
    fb = (ab * 2) << GUARD;
    p0 = round_term((n * e0) / dg);
    p1 = round_term((n * e1) / dg);
    p2 = round_term((n * fb) / dg);
    if (b < 0) p2 = -p2;
    w0 = clamp32(p0);
    w1 = clamp32(p1);
    w2 = clamp32(p2);
    r.proj_top_left     = w0[31:0];
    r.proj_top_right    = w2[31:0];
    r.proj_bottom_left  = w2[31:0];
    r.proj_bottom_right = w1[31:0];
    r.overflow          = w0[32] | w1[32] | w2[32];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    psdp_pkg::result_t want;
    if (!rst && done) begin
      if (projections_due.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = projections_due.pop_front();
        if (result.proj_top_left !== want.proj_top_left)
          report_mismatch("top_left", result.proj_top_left, want.proj_top_left);
        if (result.proj_top_right !== want.proj_top_right)
          report_mismatch("top_right", result.proj_top_right, want.proj_top_right);
        if (result.proj_bottom_left !== want.proj_bottom_left)
          report_mismatch("bottom_left", result.proj_bottom_left, want.proj_bottom_left);
        if (result.proj_bottom_right !== want.proj_bottom_right)
          report_mismatch("bottom_right", result.proj_bottom_right,
                          want.proj_bottom_right);
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", 32'(result.overflow), 32'(want.overflow));
      end
    end
  end

  // Send one request, with an optional random gap first
  task automatic send_request(psdp_pkg::request_t rq, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    projections_due.push_back(project_psd(rq));
  endtask

  task automatic hold_request;
    start <= 1'b0;
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 4) == 0 ? 32'h80000000 : 32'h7fffffff;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 32'h40000)) - 32'h20000);
      4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return {{2{$urandom_range(0, 1) == 1}}, 30'($urandom)};
    endcase
  endfunction

  function automatic psdp_pkg::request_t mk(logic [31:0] a, logic [31:0] t,
                                            logic [31:0] b, logic [31:0] c);
    psdp_pkg::request_t r;
    r.top_left = a;
    r.top_right = t;
    r.bottom_left = b;
    r.bottom_right = c;
    return r;
  endfunction

  // Extremes, pass-through, all-negative, mixed and saturating cases
  task automatic test_directed;
    send_request(mk(0, 0, 0, 0), 0);
    send_request(mk(32'h10000, 32'h1234, 0, 32'h20000), 0);
    send_request(mk(-32'sh10000, 5, 0, -32'sh20000), 0);
    send_request(mk(32'h10000, 7, 0, -32'sh10000), 0);
    send_request(mk(32'h10000, 0, 32'h30000, 32'h10000), 0);
    send_request(mk(-32'sh10000, 0, 32'h30000, -32'sh10000), 0);
    send_request(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
    send_request(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000), 0);
    send_request(mk(32'h7fffffff, 0, 32'h80000000, 32'h80000000), 0);
    send_request(mk(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff), 0);
    send_request(mk(32'h7fffffff, 0, 32'h80000000, 32'h7fffffff), 0);
    send_request(mk(32'h80000000, 32'hffffffff, 0, 32'h80000000), 0);
    send_request(mk(32'h7fffffff, 0, 0, 32'h80000000), 0);
    send_request(mk(1, 32'h55555555, 1, 1), 0);
    send_request(mk(1, 32'haaaaaaaa, 2, 1), 0);
    send_request(mk(-1, 0, 1, -1), 0);
    send_request(mk(0, 0, -1, 0), 0);
    send_request(mk(32'h10000, 0, 32'h10000, 32'h10000), 0);
    send_request(mk(2, 0, 32'h7fffffff, 32'h7ffffff0), 0);
    hold_request();
  endtask

  // Pause the sender until every result has come back, then send one more request
  task automatic test_drain_pause;
    hold_request();
    while (projections_due.size() != 0) @(posedge clk);
    send_request(mk(3, 9, -5, 2), 0);
    hold_request();
  endtask

  // Random matrices, with bursts and random gaps
  task automatic test_random(int count);
    bit burst;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) burst = $urandom_range(0, 2) == 0;
      send_request(mk(rand_entry(), rand_entry(), rand_entry(), rand_entry()), !burst);
    end
    hold_request();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(1700);
    while (projections_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
